@@ rtl/tcl_pkg.sv @@
// Package for the two-class longest-wait dispatcher.
// Holds status codes, class codes and the stored entry type; no dependencies.
package tcl_pkg;
    localparam int unsigned PET_W  = 16;
    localparam int unsigned WAIT_W = 8;
    localparam int unsigned ENTRY_W = PET_W + WAIT_W;

    typedef enum logic [1:0] {
        ST_ADOPTED = 2'd0,
        ST_NONE    = 2'd1,
        ST_STORED  = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    localparam logic REQ_ADOPT  = 1'b0;
    localparam logic REQ_ARRIVE = 1'b1;
    localparam logic CLS_CAT = 1'b0;
    localparam logic CLS_DOG = 1'b1;

    typedef logic [ENTRY_W-1:0] t_entry;

    typedef struct packed {
        logic              req_type;
        logic              species;
        logic [PET_W-1:0]  pet_id;
        logic [WAIT_W-1:0] wait_time;
        logic [PET_W-1:0]  adopter_id;
    } t_req;

    typedef struct packed {
        t_status          status;
        logic [PET_W-1:0] out_adopter;
        logic [PET_W-1:0] out_pet;
        logic             out_species;
    } t_rsp;
endpackage

@@ rtl/tcl_if.sv @@
// Valid/ready channel carrying one beat of a packed payload.
// Used for request and response channels of the dispatcher; depends on nothing.
interface tcl_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/two_class_longest_wait_dispatcher_unit.sv @@
// Top level of the two-class longest-wait dispatcher.
// Depends on tcl_pkg, tcl_if and tcl_ram.
//
// Each class keeps its entries unordered in one RAM (one bank per class).
// An arrival writes at the count, and its result is loaded at the edge that
// accepts the beat; the same holds for a request that finds both classes
// empty. A request scans the served class one entry per cycle through the
// registered read port, then moves the last entry into the freed slot. The
// result is loaded in S_OUT, after the states S_SCAN, S_LAST and S_MOVE, and
// the next beat can be taken after the return to S_IDLE. One
// item is in work at a time. The response register parts the two sides: a
// new beat is taken while the last result is leaving in the same cycle.
module two_class_longest_wait_dispatcher_unit #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tcl_if.sink   i_req,
    tcl_if.source o_rsp
);
    import tcl_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_MOVE, S_OUT} t_state;

    t_state          r_state;
    t_req            r_req;
    logic            r_cls;
    logic [CW-1:0]   r_cnt [2];
    logic [CW-1:0]   r_idx;
    logic [AW-1:0]   r_best_idx;
    t_entry          r_best;
    logic            r_rsp_valid;
    t_rsp            r_rsp;

    logic            we [2];
    logic [AW-1:0]   waddr;
    t_entry          wdata;
    logic [AW-1:0]   raddr;
    t_entry          rdata [2];
    t_entry          rd;
    logic [CW-1:0]   n_cnt;
    logic            n_cls;
    logic [AW-1:0]   prev_idx;
    logic            rsp_load;

    for (genvar c = 0; c < 2; c++) begin : g_bank
        tcl_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
            .i_clk  (i_clk),
            .i_we   (we[c]),
            .i_waddr(waddr),
            .i_wdata(wdata),
            .i_raddr(raddr),
            .o_rdata(rdata[c])
        );
    end

    assign i_req.ready = (r_state == S_IDLE) && (!r_rsp_valid || o_rsp.ready);
    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;
    assign rd          = rdata[r_cls];
    assign prev_idx    = AW'(r_idx - CW'(1));
    assign n_cnt       = r_cnt[r_cls] - CW'(1);
    assign rsp_load    = (r_state == S_IDLE && i_req.valid && i_req.ready
                          && (i_req.data.req_type == REQ_ARRIVE || r_cnt[n_cls] == '0))
                         || r_state == S_OUT;

    always_comb begin
        n_cls = i_req.data.species;
        if (r_cnt[n_cls] == '0 && r_cnt[!n_cls] != '0) begin
            n_cls = !n_cls;
        end
    end

    always_comb begin
        we[0] = 1'b0;
        we[1] = 1'b0;
        waddr = r_best_idx;
        wdata = rd;
        raddr = (r_state == S_IDLE) ? '0 : AW'(r_idx);
        if (r_state == S_IDLE && i_req.valid && i_req.ready
                && i_req.data.req_type == REQ_ARRIVE
                && r_cnt[i_req.data.species] < CW'(CAPACITY)) begin
            we[i_req.data.species] = 1'b1;
            waddr = AW'(r_cnt[i_req.data.species]);
            wdata = {i_req.data.wait_time, i_req.data.pet_id};
        end else if (r_state == S_LAST) begin
            raddr = AW'(n_cnt);
        end else if (r_state == S_MOVE) begin
            we[r_cls] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt[0]    <= '0;
            r_cnt[1]    <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (o_rsp.ready && !rsp_load) begin
                r_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_req <= i_req.data;
                        if (i_req.data.req_type == REQ_ARRIVE) begin
                            r_rsp_valid       <= 1'b1;
                            r_rsp.out_adopter <= '0;
                            r_rsp.out_pet     <= '0;
                            r_rsp.out_species <= i_req.data.species;
                            if (r_cnt[i_req.data.species] < CW'(CAPACITY)) begin
                                r_rsp.status <= ST_STORED;
                                r_cnt[i_req.data.species] <=
                                    r_cnt[i_req.data.species] + CW'(1);
                            end else begin
                                r_rsp.status <= ST_FULL;
                            end
                        end else if (r_cnt[n_cls] == '0) begin
                            r_rsp_valid       <= 1'b1;
                            r_rsp.status      <= ST_NONE;
                            r_rsp.out_adopter <= i_req.data.adopter_id;
                            r_rsp.out_pet     <= '0;
                            r_rsp.out_species <= CLS_CAT;
                        end else begin
                            r_cls   <= n_cls;
                            r_idx   <= CW'(1);
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_idx == CW'(1) || rd > r_best) begin
                        r_best     <= rd;
                        r_best_idx <= prev_idx;
                    end
                    if (r_idx == r_cnt[r_cls]) begin
                        r_state <= S_LAST;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_LAST: begin
                    r_state <= S_MOVE;
                end
                S_MOVE: begin
                    r_cnt[r_cls] <= n_cnt;
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    r_rsp_valid       <= 1'b1;
                    r_rsp.status      <= ST_ADOPTED;
                    r_rsp.out_adopter <= r_req.adopter_id;
                    r_rsp.out_pet     <= r_best[PET_W-1:0];
                    r_rsp.out_species <= r_cls;
                    r_state           <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[0] <= CW'(CAPACITY) && r_cnt[1] <= CW'(CAPACITY))
        else $error("class count above capacity");
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_cnt[r_cls] != '0)
        else $error("scan of an empty class");
    a_adopt_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MOVE |=> r_cnt[r_cls] == $past(r_cnt[r_cls]) - CW'(1))
        else $error("adoption did not remove one entry");
endmodule

@@ rtl/tcl_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tcl_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
